// ===== rtl/xcw_pkg.sv =====
`default_nettype none
package xcw_pkg;

  // Header de-obfuscation key and framing
  localparam logic [7:0]  OBF_KEY   = 8'h69;
  localparam logic [31:0] HDR_BYTES = 32'd8;
  localparam logic [31:0] MIN_FILE  = 32'd16;
  localparam logic [31:0] ROOT_TAG  = 32'h544C4B42;
  localparam logic [7:0]  CHAR_LO   = 8'h20;
  localparam logic [7:0]  CHAR_HI   = 8'h7e;

  // Configuration register indexes
  localparam logic CFG_FILE_SIZE = 1'b0;
  localparam logic CFG_REC_LIMIT = 1'b1;

  localparam logic [31:0] FILE_SIZE_RST = 32'd0;
  localparam logic [15:0] REC_LIMIT_RST = 16'hFFFF;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Verdict codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_TOO_SMALL   = 4'd1;
  localparam logic [3:0] ST_BAD_ROOT    = 4'd2;
  localparam logic [3:0] ST_ROOT_SIZE   = 4'd3;
  localparam logic [3:0] ST_TOO_MANY    = 4'd4;
  localparam logic [3:0] ST_BAD_CHAR    = 4'd5;
  localparam logic [3:0] ST_UNDER_HDR   = 4'd6;
  localparam logic [3:0] ST_OVERRUN     = 4'd7;
  localparam logic [3:0] ST_NOT_TILED   = 4'd8;
  localparam logic [3:0] ST_NO_CHILDREN = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } xcw_in_t;

  typedef struct packed {
    logic        is_entry;
    logic        is_final;
    logic [31:0] header_offset;
    logic [31:0] payload_offset;
    logic [31:0] payload_size;
    logic [31:0] chunk_tag;
    logic [15:0] entry_number;
    logic [3:0]  status;
  } xcw_out_t;

  // Classified byte handed from front to back
  typedef struct packed {
    logic [7:0] plain_byte;
    logic       first_byte;
    logic       printable;
  } xcw_item_t;

endpackage
`default_nettype wire

// ===== rtl/xcw_front.sv =====
`default_nettype none
module xcw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  xcw_pkg::xcw_in_t    in_data_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output xcw_pkg::xcw_item_t  q_item_o
);
  import xcw_pkg::*;

  logic [7:0] plain;
  logic       restart_q;

  // Stall while the queue has no room
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  // Track the first transfer after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_q <= 1'b1;
    end else if (q_push_o) begin
      restart_q <= 1'b0;
    end
  end

  // Undo the XOR and classify the byte as a tag character
  assign plain = in_data_i.data_byte ^ OBF_KEY;
  assign q_item_o.plain_byte = plain;
  assign q_item_o.first_byte = in_data_i.first_byte | restart_q;
  assign q_item_o.printable  = (plain >= CHAR_LO) && (plain <= CHAR_HI);

endmodule
`default_nettype wire

// ===== rtl/xcw_fifo.sv =====
`default_nettype none
module xcw_fifo #(
  parameter int unsigned DEPTH = xcw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  xcw_pkg::xcw_item_t  push_item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output xcw_pkg::xcw_item_t  pop_item_o
);
  import xcw_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  xcw_item_t       mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q;
  logic [AW-1:0]   rd_ptr_q;
  logic [CW-1:0]   count_q;

  assign full_o     = (count_q == CW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/xcw_back.sv =====
`default_nettype none
module xcw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                q_valid_i,
  input  xcw_pkg::xcw_item_t  q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output xcw_pkg::xcw_out_t   out_data_o
);
  import xcw_pkg::*;

  typedef enum logic [1:0] {
    PH_ROOT,
    PH_CHILD,
    PH_PAYLOAD
  } phase_e;

  // Configuration
  logic [31:0] file_size_q;
  logic [15:0] max_rec_q;

  // Walk state
  phase_e      phase_q, phase_d;
  logic [2:0]  fill_q, fill_d;
  logic [55:0] shift_q, shift_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] start_q, start_d;
  logic [15:0] count_q, count_d;
  logic        fin_q, fin_d;
  logic        tagok_q, tagok_d;

  // Result register
  logic        out_valid_q;
  xcw_out_t    out_q;
  logic        res_vld;
  xcw_out_t    res;

  // State after an optional restart
  phase_e      b_phase;
  logic [2:0]  b_fill;
  logic [55:0] b_shift;
  logic [31:0] b_start;
  logic [15:0] b_count;
  logic        b_fin;
  logic        b_tagok;
  logic        first;

  logic [63:0] full_shift;
  logic [31:0] hdr_tag;
  logic [31:0] hdr_size;
  logic [32:0] child_end;
  logic [31:0] ac_start;
  logic [15:0] ac_count;
  logic        ac_room;
  logic        ac_too_many;
  logic        ac_final;
  logic [3:0]  ac_status;

  assign q_pop_o = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign first   = q_item_i.first_byte;

  assign b_phase = first ? PH_ROOT : phase_q;
  assign b_fill  = first ? 3'd0    : fill_q;
  assign b_shift = first ? '0      : shift_q;
  assign b_start = first ? '0      : start_q;
  assign b_count = first ? '0      : count_q;
  assign b_fin   = first ? 1'b0    : fin_q;
  assign b_tagok = first ? 1'b0    : tagok_q;

  // Header fields once the eighth byte arrives
  assign full_shift = {b_shift, q_item_i.plain_byte};
  assign hdr_tag    = full_shift[63:32];
  assign hdr_size   = full_shift[31:0];
  assign child_end  = {1'b0, b_start} + {1'b0, hdr_size};

  // Decide what follows a chunk or the root header
  always_comb begin
    unique case (b_phase)
      PH_PAYLOAD: ac_start = b_start;
      PH_ROOT:    ac_start = HDR_BYTES;
      default:    ac_start = child_end[31:0];
    endcase
  end
  assign ac_count    = (b_phase == PH_CHILD) ? b_count + 16'd1 : b_count;
  assign ac_room     = ({1'b0, ac_start} + {1'b0, HDR_BYTES}) <= {1'b0, file_size_q};
  assign ac_too_many = ac_count >= max_rec_q;
  assign ac_final    = ~ac_room | ac_too_many;

  always_comb begin
    priority if (ac_room) begin
      ac_status = ST_TOO_MANY;
    end else if (ac_start != file_size_q) begin
      ac_status = ST_NOT_TILED;
    end else if (ac_count == '0) begin
      ac_status = ST_NO_CHILDREN;
    end else begin
      ac_status = ST_OK;
    end
  end

  // Step the walk for one byte
  always_comb begin
    phase_d = b_phase;
    fill_d  = b_fill;
    shift_d = b_shift;
    rem_d   = rem_q;
    start_d = b_start;
    count_d = b_count;
    fin_d   = b_fin;
    tagok_d = b_tagok;
    res     = '0;
    res_vld = 1'b0;
    if (!b_fin) begin
      unique case (b_phase)
        PH_PAYLOAD: begin
          rem_d = rem_q - 32'd1;
          if (rem_q == 32'd1) begin
            if (ac_final) begin
              fin_d        = 1'b1;
              res_vld      = 1'b1;
              res.is_final = 1'b1;
              res.status   = ac_status;
            end else begin
              phase_d = PH_CHILD;
              fill_d  = 3'd0;
            end
          end
        end
        PH_ROOT, PH_CHILD: begin
          if (b_phase == PH_ROOT && b_fill == 3'd0 && file_size_q < MIN_FILE) begin
            fin_d        = 1'b1;
            res_vld      = 1'b1;
            res.is_final = 1'b1;
            res.status   = ST_TOO_SMALL;
          end else begin
            shift_d = full_shift[55:0];
            if (b_fill == 3'd0) begin
              tagok_d = q_item_i.printable;
            end else if (b_fill < 3'd4) begin
              tagok_d = b_tagok & q_item_i.printable;
            end
            if (b_fill != 3'd7) begin
              fill_d = b_fill + 3'd1;
            end else begin
              fill_d = 3'd0;
              if (b_phase == PH_ROOT) begin
                priority if (hdr_tag != ROOT_TAG) begin
                  fin_d        = 1'b1;
                  res_vld      = 1'b1;
                  res.is_final = 1'b1;
                  res.status   = ST_BAD_ROOT;
                end else if (hdr_size != file_size_q) begin
                  fin_d        = 1'b1;
                  res_vld      = 1'b1;
                  res.is_final = 1'b1;
                  res.status   = ST_ROOT_SIZE;
                end else begin
                  start_d = HDR_BYTES;
                  if (ac_final) begin
                    fin_d        = 1'b1;
                    res_vld      = 1'b1;
                    res.is_final = 1'b1;
                    res.status   = ac_status;
                  end else begin
                    phase_d = PH_CHILD;
                  end
                end
              end else begin
                priority if (!b_tagok) begin
                  fin_d        = 1'b1;
                  res_vld      = 1'b1;
                  res.is_final = 1'b1;
                  res.status   = ST_BAD_CHAR;
                end else if (hdr_size < HDR_BYTES) begin
                  fin_d        = 1'b1;
                  res_vld      = 1'b1;
                  res.is_final = 1'b1;
                  res.status   = ST_UNDER_HDR;
                end else if (child_end > {1'b0, file_size_q}) begin
                  fin_d        = 1'b1;
                  res_vld      = 1'b1;
                  res.is_final = 1'b1;
                  res.status   = ST_OVERRUN;
                end else begin
                  // Report the child and skip its payload
                  count_d            = ac_count;
                  res_vld            = 1'b1;
                  res.is_entry       = 1'b1;
                  res.header_offset  = b_start;
                  res.payload_offset = b_start + HDR_BYTES;
                  res.payload_size   = hdr_size - HDR_BYTES;
                  res.chunk_tag      = hdr_tag;
                  res.entry_number   = ac_count;
                  start_d            = child_end[31:0];
                  rem_d              = hdr_size - HDR_BYTES;
                  if (hdr_size != HDR_BYTES) begin
                    phase_d = PH_PAYLOAD;
                  end else if (ac_final) begin
                    fin_d        = 1'b1;
                    res.is_final = 1'b1;
                    res.status   = ac_status;
                  end
                end
              end
            end
          end
        end
        default: begin
          phase_d = PH_ROOT;
        end
      endcase
    end
  end

  // Hold state, configuration and the result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= FILE_SIZE_RST;
      max_rec_q   <= REC_LIMIT_RST;
      phase_q     <= PH_ROOT;
      fill_q      <= 3'd0;
      shift_q     <= '0;
      rem_q       <= '0;
      start_q     <= '0;
      count_q     <= '0;
      fin_q       <= 1'b0;
      tagok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FILE_SIZE: file_size_q <= cfg_data_i;
          CFG_REC_LIMIT: max_rec_q   <= cfg_data_i[15:0];
          default:       file_size_q <= file_size_q;
        endcase
      end
      if (q_pop_o) begin
        phase_q     <= phase_d;
        fill_q      <= fill_d;
        shift_q     <= shift_d;
        rem_q       <= rem_d;
        start_q     <= start_d;
        count_q     <= count_d;
        fin_q       <= fin_d;
        tagok_q     <= tagok_d;
        out_valid_q <= res_vld;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (q_pop_o && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/xor_chunk_container_walker.sv =====
// Path: a byte passes through the front queue, then the walk engine registers
// its result, which then waits out any output stall.
// Throughput: one byte per cycle while no output stall holds a result; the
// walk engine steps its state once a byte, also for bytes that give no result.
// Reset (rst_ni low, asynchronous) empties the queue, clears the walk to the
// root header and sets file_size to 0 and the record limit to 65535.
`default_nettype none
module xor_chunk_container_walker #(
  parameter int unsigned QUEUE_DEPTH = xcw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  xcw_pkg::xcw_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output xcw_pkg::xcw_out_t  out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import xcw_pkg::*;

  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_valid;
  xcw_item_t push_item;
  xcw_item_t pop_item;

  xcw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  xcw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  xcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== rtl/xcw_checker.sv =====
`default_nettype none
module xcw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input xcw_pkg::xcw_out_t  out_data_i
);
  import xcw_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // Every result reports a child or a verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_data_i.is_entry || out_data_i.is_final))
    else $error("empty result");

  // Status only rides on a verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.is_final |-> out_data_i.status == ST_OK)
    else $error("status without verdict");

  // Child fields are clear on a bare verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.is_entry |->
      (out_data_i.header_offset == '0) && (out_data_i.entry_number == '0) &&
      (out_data_i.chunk_tag == '0) && (out_data_i.payload_size == '0))
    else $error("child fields set on verdict");

  // Payload starts right after the child header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.is_entry |->
      out_data_i.payload_offset == out_data_i.header_offset + HDR_BYTES)
    else $error("payload offset mismatch");

endmodule

bind xor_chunk_container_walker xcw_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
`default_nettype wire

// ===== dv/xor_chunk_container_walker_test.sv =====
module xor_chunk_container_walker_test;
  import xcw_pkg::*;

  typedef enum logic [1:0] {
    WALK_ROOT,
    WALK_CHILD,
    WALK_PAYLOAD
  } walk_phase_e;

  // Expected results of the chunk walk, kept in step with accepted bytes
  class walk_scoreboard;
    logic [31:0] file_size;
    logic [15:0] rec_limit;
    logic [63:0] header_shift;
    logic [2:0]  header_fill;
    logic [31:0] payload_left;
    logic [31:0] chunk_start;
    logic [15:0] child_count;
    walk_phase_e phase;
    bit          finished;
    xcw_out_t    expected_q[$];
    int unsigned mismatches;
    int unsigned bytes_walked;
    int unsigned entries_seen;
    int unsigned verdicts_seen;
    bit [15:0]   codes_seen;

    function new();
      file_size = FILE_SIZE_RST;
      rec_limit = REC_LIMIT_RST;
      restart_walk();
    endfunction

    function void restart_walk();
      header_shift = '0;
      header_fill  = '0;
      payload_left = '0;
      chunk_start  = '0;
      child_count  = '0;
      phase        = WALK_ROOT;
      finished     = 1'b0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == CFG_FILE_SIZE) file_size = value;
      else rec_limit = value[15:0];
    endfunction

    function bit give_verdict(inout xcw_out_t res, input logic [3:0] code);
      res.is_final = 1'b1;
      res.status   = code;
      finished     = 1'b1;
      return 1'b1;
    endfunction

    // Decide what follows the chunk (or root header) ending at chunk_start
    function bit close_chunk(inout xcw_out_t res, input bit has_entry);
      if ({1'b0, chunk_start} + 33'd8 <= {1'b0, file_size}) begin
        if (child_count >= rec_limit) return give_verdict(res, ST_TOO_MANY);
        phase       = WALK_CHILD;
        header_fill = '0;
        return has_entry;
      end
      if (chunk_start != file_size) return give_verdict(res, ST_NOT_TILED);
      if (child_count == 0) return give_verdict(res, ST_NO_CHILDREN);
      return give_verdict(res, ST_OK);
    endfunction

    function void take_byte(xcw_in_t it);
      logic [7:0]  plain;
      logic [7:0]  ch;
      logic [31:0] tag;
      logic [31:0] len;
      xcw_out_t    res;
      bit          any;
      bit          bad_char;
      int          k;
      plain = it.data_byte ^ OBF_KEY;
      res   = '0;
      any   = 1'b0;
      if (it.first_byte) restart_walk();
      if (finished) return;
      bytes_walked++;
      if (phase == WALK_PAYLOAD) begin
        payload_left = payload_left - 1;
        if (payload_left != 0) return;
        any = close_chunk(res, 1'b0);
      end else if (phase == WALK_ROOT && header_fill == 0 && file_size < MIN_FILE) begin
        any = give_verdict(res, ST_TOO_SMALL);
      end else begin
        header_shift = {header_shift[55:0], plain};
        if (header_fill < 3'd7) begin
          header_fill++;
          return;
        end
        header_fill = '0;
        tag = header_shift[63:32];
        len = header_shift[31:0];
        bad_char = 1'b0;
        for (k = 0; k < 4; k++) begin
          ch = tag[31 - 8*k -: 8];
          if (ch < CHAR_LO || ch > CHAR_HI) bad_char = 1'b1;
        end
        if (phase == WALK_ROOT) begin
          if (tag != ROOT_TAG) any = give_verdict(res, ST_BAD_ROOT);
          else if (len != file_size) any = give_verdict(res, ST_ROOT_SIZE);
          else begin
            chunk_start = HDR_BYTES;
            any = close_chunk(res, 1'b0);
          end
        end else if (bad_char) begin
          any = give_verdict(res, ST_BAD_CHAR);
        end else if (len < HDR_BYTES) begin
          any = give_verdict(res, ST_UNDER_HDR);
        end else if ({1'b0, chunk_start} + {1'b0, len} > {1'b0, file_size}) begin
          any = give_verdict(res, ST_OVERRUN);
        end else begin
          child_count++;
          res.is_entry       = 1'b1;
          res.header_offset  = chunk_start;
          res.payload_offset = chunk_start + HDR_BYTES;
          res.payload_size   = len - HDR_BYTES;
          res.chunk_tag      = tag;
          res.entry_number   = child_count;
          chunk_start  = chunk_start + len;
          payload_left = len - HDR_BYTES;
          if (payload_left != 0) begin
            phase = WALK_PAYLOAD;
            any   = 1'b1;
          end else begin
            any = close_chunk(res, 1'b1);
          end
        end
      end
      if (any) expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
      end
    endfunction

    function void check_result(xcw_out_t got);
      xcw_out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result %h with none expected", $realtime, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.is_entry) entries_seen++;
      if (got.is_final) begin
        verdicts_seen++;
        codes_seen[got.status] = 1'b1;
      end
      compare_field("is_entry", want.is_entry, got.is_entry);
      compare_field("is_final", want.is_final, got.is_final);
      compare_field("header_offset", want.header_offset, got.header_offset);
      compare_field("payload_offset", want.payload_offset, got.payload_offset);
      compare_field("payload_size", want.payload_size, got.payload_size);
      compare_field("chunk_tag", want.chunk_tag, got.chunk_tag);
      compare_field("entry_number", want.entry_number, got.entry_number);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  xcw_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  xcw_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_FILE_SIZE;
  logic [31:0] cfg_data = '0;

  walk_scoreboard board = new();

  xcw_in_t     stream_q[$];
  int          header_at[$];
  int          burst_left = 0;
  int unsigned gap_max = 0;
  int unsigned stall_pct = 0;
  int          stall_run = 0;
  bit          stall_now = 1'b0;
  int unsigned streams_sent = 0;
  int unsigned items_sent = 0;

  xor_chunk_container_walker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the output in runs, with density set per stream
  always @(negedge clk) begin
    if (stall_run <= 0) begin
      stall_run = $urandom_range(1, 8);
      stall_now = ($urandom_range(0, 99) < stall_pct);
    end
    stall_run--;
    out_stall <= stall_now;
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  function automatic void add_byte(logic [7:0] raw, bit first = 1'b0);
    xcw_in_t it;
    it.data_byte  = raw;
    it.first_byte = first;
    stream_q.push_back(it);
  endfunction

  // Obfuscated 8-byte header: tag then big-endian size
  function automatic void add_header(logic [31:0] tag, logic [31:0] len);
    logic [63:0] word;
    word = {tag, len};
    header_at.push_back(stream_q.size());
    for (int i = 0; i < 8; i++) add_byte(word[63 - 8*i -: 8] ^ OBF_KEY);
  endfunction

  function automatic void add_payload(int unsigned n);
    repeat (n) add_byte($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] printable_tag();
    logic [31:0] tag;
    for (int i = 0; i < 4; i++) tag[8*i +: 8] = $urandom_range(CHAR_LO, CHAR_HI);
    return tag;
  endfunction

  // Well-formed container; slack added to the root size breaks the tiling
  function automatic logic [31:0] build_walk(int unsigned kids, int unsigned max_pay,
                                             int unsigned slack);
    int unsigned pay[$];
    logic [31:0] total;
    total = HDR_BYTES + slack;
    repeat (kids) begin
      pay.push_back(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, max_pay));
      total += pay[$] + HDR_BYTES;
    end
    add_header(ROOT_TAG, total);
    foreach (pay[i]) begin
      add_header(printable_tag(), pay[i] + HDR_BYTES);
      add_payload(pay[i]);
    end
    return total;
  endfunction

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, value);
  endtask

  // Offer one byte, in bursts with gaps, and hold it until the transfer
  task automatic send_item(xcw_in_t it);
    if (gap_max != 0 && burst_left <= 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_byte(it);
    items_sent++;
  endtask

  // Drop valid and wait out every expected result plus the pipeline
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_item(stream_q[i]);
    stream_q.delete();
    header_at.delete();
    streams_sent++;
    drain();
  endtask

  // Directed containers: boundaries, every verdict and restart behavior
  task automatic run_directed();
    xcw_in_t     held[$];
    logic [31:0] tag;
    // no restart mark on byte zero after reset; junk after the verdict
    write_reg(CFG_FILE_SIZE, 32'd24);
    add_header(ROOT_TAG, 32'd24);
    add_header("DATA", 32'd16);
    add_payload(8);
    add_byte(8'hff);
    add_byte(8'h00);
    send_stream();
    // too small, at both ends of the short range
    write_reg(CFG_FILE_SIZE, 32'd0);
    add_byte(8'h3d, 1'b1);
    add_byte(8'ha5);
    send_stream();
    write_reg(CFG_FILE_SIZE, 32'd15);
    add_byte(8'h3d, 1'b1);
    send_stream();
    // bad root tag, then root size mismatch
    write_reg(CFG_FILE_SIZE, 32'd40);
    add_header("TLKA", 32'd40);
    stream_q[0].first_byte = 1'b1;
    add_header(ROOT_TAG, 32'd40);
    send_stream();
    add_header(ROOT_TAG, 32'd41);
    stream_q[0].first_byte = 1'b1;
    send_stream();
    // no records allowed: fail right after the root header
    write_reg(CFG_REC_LIMIT, 32'd0);
    write_reg(CFG_FILE_SIZE, 32'd16);
    add_header(ROOT_TAG, 32'd16);
    stream_q[0].first_byte = 1'b1;
    add_header("ABCD", 32'd8);
    send_stream();
    // one record allowed: empty child carries both entry and too-many verdict
    write_reg(CFG_REC_LIMIT, 32'd1);
    write_reg(CFG_FILE_SIZE, 32'd32);
    add_header(ROOT_TAG, 32'd32);
    stream_q[0].first_byte = 1'b1;
    add_header("ONE ", 32'd8);
    add_header("TWO ", 32'd16);
    add_payload(8);
    send_stream();
    // boundary tag characters, empty last child: entry and ok verdict together
    write_reg(CFG_REC_LIMIT, 32'd65535);
    write_reg(CFG_FILE_SIZE, 32'd16);
    add_header(ROOT_TAG, 32'd16);
    stream_q[0].first_byte = 1'b1;
    add_header(32'h207e207e, 32'd8);
    send_stream();
    gap_max   = 4;
    stall_pct = 50;
    // bad tag character in each position; it wins over a short size
    write_reg(CFG_FILE_SIZE, 32'd24);
    for (int p = 0; p < 4; p++) begin
      tag = "GOOD";
      tag[31 - 8*p -: 8] = p[0] ? 8'h7f : 8'h1f;
      add_header(ROOT_TAG, 32'd24);
      stream_q[0].first_byte = 1'b1;
      add_header(tag, 32'd3);
      send_stream();
    end
    // size under the header length
    add_header(ROOT_TAG, 32'd24);
    stream_q[0].first_byte = 1'b1;
    add_header("SIZE", 32'd7);
    add_header(ROOT_TAG, 32'd24);
    stream_q[16].first_byte = 1'b1;
    add_header("ZERO", 32'd0);
    send_stream();
    // child runs one byte past the end
    write_reg(CFG_FILE_SIZE, 32'd32);
    add_header(ROOT_TAG, 32'd32);
    stream_q[0].first_byte = 1'b1;
    add_header("OVER", 32'd25);
    send_stream();
    // chunks stop three bytes short of the end
    write_reg(CFG_FILE_SIZE, 32'd27);
    add_header(ROOT_TAG, 32'd27);
    stream_q[0].first_byte = 1'b1;
    add_header("TILE", 32'd16);
    add_payload(8);
    send_stream();
    // shrink file_size mid-walk so the root header alone covers the file
    write_reg(CFG_FILE_SIZE, 32'd16);
    add_header(ROOT_TAG, 32'd8);
    stream_q[0].first_byte = 1'b1;
    held = stream_q;
    stream_q = held[0:0];
    send_stream();
    write_reg(CFG_FILE_SIZE, 32'd8);
    stream_q = held[1:7];
    send_stream();
    // largest file: child that just fits, then restart inside its payload
    write_reg(CFG_FILE_SIZE, 32'hffffffff);
    add_header(ROOT_TAG, 32'hffffffff);
    stream_q[0].first_byte = 1'b1;
    add_header("HUGE", 32'hfffffff7);
    add_payload(10);
    send_stream();
    add_header(ROOT_TAG, 32'hffffffff);
    stream_q[0].first_byte = 1'b1;
    add_header("HUGE", 32'hfffffff8);
    send_stream();
    // restart in the middle of the root header
    write_reg(CFG_FILE_SIZE, 32'd24);
    add_header(ROOT_TAG, 32'd24);
    stream_q[0].first_byte = 1'b1;
    stream_q = stream_q[0:4];
    add_header(ROOT_TAG, 32'd24);
    stream_q[5].first_byte = 1'b1;
    add_header("BACK", 32'd16);
    add_payload(8);
    send_stream();
  endtask

  // Random containers, mostly well formed, some damaged or plain noise
  task automatic run_random();
    logic [31:0] fsize;
    int unsigned pick;
    int          cut;
    while (items_sent < 1800) begin
      case ($urandom_range(0, 3))
        0: gap_max = 0;
        1: gap_max = 0;
        2: gap_max = 3;
        default: gap_max = 8;
      endcase
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) write_reg(CFG_REC_LIMIT, $urandom_range(0, 3));
      else if (pick < 3) write_reg(CFG_REC_LIMIT, 32'd65535);
      fsize = build_walk($urandom_range(1, 5), 20,
                         ($urandom_range(0, 9) == 0) ? $urandom_range(1, 7) : 0);
      pick = $urandom_range(0, 99);
      if (pick >= 65 && pick < 77) begin
        // damage one header byte
        cut = header_at[$urandom_range(0, header_at.size() - 1)] + $urandom_range(0, 7);
        stream_q[cut].data_byte = $urandom_range(0, 255);
      end else if (pick >= 77 && pick < 85) begin
        fsize = fsize ^ (32'd1 << $urandom_range(0, 31));
      end else if (pick >= 85 && pick < 92) begin
        cut = $urandom_range(0, stream_q.size() - 1);
        stream_q = stream_q[0:cut];
      end else if (pick >= 92) begin
        stream_q.delete();
        repeat ($urandom_range(4, 30))
          add_byte($urandom_range(0, 255), $urandom_range(0, 15) == 0);
      end
      stream_q[0].first_byte = 1'b1;
      repeat ($urandom_range(0, 3)) add_byte($urandom_range(0, 255));
      write_reg(CFG_FILE_SIZE, fsize);
      send_stream();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    repeat (20) @(posedge clk);
    $display("Walked %0d file bytes in %0d streams under bursty input and output stalls",
             board.bytes_walked, streams_sent);
    $display("Checked %0d child entries and %0d verdicts, verdict codes hit %b",
             board.entries_seen, board.verdicts_seen, board.codes_seen);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               board.mismatches, board.expected_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run
  initial begin
    #3000000;
    $display("Timed out with %0d results outstanding", board.expected_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/xcw_pkg.sv
rtl/xcw_front.sv
rtl/xcw_fifo.sv
rtl/xcw_back.sv
rtl/xor_chunk_container_walker.sv
rtl/xcw_checker.sv
dv/xor_chunk_container_walker_test.sv
